>>> design/u8d_pkg.sv
// shared types and constants of the utf-8 stream decoder
package u8d_pkg;

  localparam int unsigned CpWidth = 21;

  localparam logic [CpWidth-1:0] ReplCp = 21'h00FFFD;

  localparam logic [1:0] ContTag = 2'b10;

  localparam logic [7:0] AsciiTop = 8'h80;
  localparam logic [7:0] LeadTwo = 8'hC0;
  localparam logic [7:0] LeadThree = 8'hE0;
  localparam logic [7:0] LeadFour = 8'hF0;
  localparam logic [7:0] LeadBad = 8'hF8;

  // one decoded byte: replacements, an optional code point, then replacements
  typedef struct packed {
    logic [2:0]         pre_reps;
    logic               has_data;
    logic [CpWidth-1:0] data_cp;
    logic [1:0]         post_reps;
    logic               fin;
  } job_t;

endpackage

>>> design/utf8_stream_decoder.sv
// top level of the utf-8 stream decoder
//
//   channel  direction  handshake            payload
//   bytes    in         push_i / full_o      text_byte_i, final_byte_i
//   results  out        pop_i / empty_o      code_point_o, replaced_o, run_last_o, text_end_o
//
// one byte is taken per cycle while the job queue has room
// a byte giving n results (one to four) holds the back end until all n are loaded
// first result of a byte goes through the job queue, then appears from the output register
// reset clears sequence state, queue pointers and output valid; no clearing pass
// full_o rises only when QueueDepth jobs wait behind a stalled or busy back end
module utf8_stream_decoder
  import u8d_pkg::*;
#(
  parameter int unsigned QueueDepth = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  output logic               full_o,
  input  logic [7:0]         text_byte_i,
  input  logic               final_byte_i,
  input  logic               pop_i,
  output logic               empty_o,
  output logic [CpWidth-1:0] code_point_o,
  output logic               replaced_o,
  output logic               run_last_o,
  output logic               text_end_o
);

  logic take;
  logic job_valid;
  job_t job_in;
  job_t job_head;
  logic q_full;
  logic q_empty;
  logic q_pop;

  assign full_o = q_full;
  assign take   = push_i && !q_full;

  u8d_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .byte_i      (text_byte_i),
    .final_i     (final_byte_i),
    .job_valid_o (job_valid),
    .job_o       (job_in)
  );

  u8d_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (take && job_valid),
    .wr_data_i (job_in),
    .rd_i      (q_pop),
    .rd_data_o (job_head),
    .full_o    (q_full),
    .empty_o   (q_empty)
  );

  u8d_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_valid_i  (!q_empty),
    .job_i        (job_head),
    .job_pop_o    (q_pop),
    .pop_i        (pop_i),
    .empty_o      (empty_o),
    .code_point_o (code_point_o),
    .replaced_o   (replaced_o),
    .run_last_o   (run_last_o),
    .text_end_o   (text_end_o)
  );

  // end of text only on the last result of a byte
  a_end_is_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && text_end_o) |-> run_last_o)
    else $error("text end without run last");

  // a replacement always carries the replacement code point
  a_repl_cp : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && replaced_o) |-> (code_point_o == ReplCp))
    else $error("replacement with wrong code point");

  // the back end retires a job only when one is queued
  a_pop_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("job retired from empty queue");

  // a retired job always leaves a result in the output register
  a_pop_loads : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |=> !empty_o)
    else $error("job retired without a result");

endmodule

>>> design/u8d_front.sv
// front end: sequence state and classification of each byte into a job
module u8d_front
  import u8d_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       take_i,
  input  logic [7:0] byte_i,
  input  logic       final_i,
  output logic       job_valid_o,
  output job_t       job_o
);

  logic [CpWidth-1:0] partial_q, partial_d;
  logic [1:0]         needed_q, needed_d;
  logic [1:0]         held_q, held_d;
  logic [1:0]         held_inc;
  logic [CpWidth-1:0] shifted;
  logic               is_cont;
  job_t               job;

  assign is_cont  = (byte_i[7:6] == ContTag);
  assign held_inc = held_q + 2'd1;
  assign shifted  = {partial_q[CpWidth-7:0], byte_i[5:0]};

  always_comb begin
    partial_d     = partial_q;
    needed_d      = needed_q;
    held_d        = held_q;
    job.pre_reps  = 3'd0;
    job.has_data  = 1'b0;
    job.data_cp   = '0;
    job.post_reps = 2'd0;
    job.fin       = final_i;

    if ((needed_q != 2'd0) && is_cont) begin
      if (held_inc == needed_q) begin
        job.has_data = 1'b1;
        job.data_cp  = shifted;
        partial_d    = '0;
        needed_d     = 2'd0;
        held_d       = 2'd0;
      end else begin
        partial_d = shifted;
        held_d    = held_inc;
      end
    end else begin
      if (needed_q != 2'd0) begin
        job.pre_reps = {1'b0, held_q} + 3'd1;
      end
      partial_d = '0;
      needed_d  = 2'd0;
      held_d    = 2'd0;
      if (byte_i < AsciiTop) begin
        job.has_data = 1'b1;
        job.data_cp  = {{(CpWidth-8){1'b0}}, byte_i};
      end else if (byte_i < LeadTwo) begin
        job.pre_reps = job.pre_reps + 3'd1;
      end else if (byte_i < LeadThree) begin
        partial_d = {{(CpWidth-5){1'b0}}, byte_i[4:0]};
        needed_d  = 2'd1;
      end else if (byte_i < LeadFour) begin
        partial_d = {{(CpWidth-4){1'b0}}, byte_i[3:0]};
        needed_d  = 2'd2;
      end else if (byte_i < LeadBad) begin
        partial_d = {{(CpWidth-3){1'b0}}, byte_i[2:0]};
        needed_d  = 2'd3;
      end else begin
        job.pre_reps = job.pre_reps + 3'd1;
      end
    end

    // early end of text
    if (final_i) begin
      if (needed_d != 2'd0) begin
        job.post_reps = held_d + 2'd1;
      end
      partial_d = '0;
      needed_d  = 2'd0;
      held_d    = 2'd0;
    end
  end

  assign job_o       = job;
  assign job_valid_o = (job.pre_reps != 3'd0) || job.has_data || (job.post_reps != 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_q <= '0;
      needed_q  <= 2'd0;
      held_q    <= 2'd0;
    end else if (take_i) begin
      partial_q <= partial_d;
      needed_q  <= needed_d;
      held_q    <= held_d;
    end
  end

endmodule

>>> design/u8d_fifo.sv
// job queue between front end and back end
module u8d_fifo
  import u8d_pkg::*;
#(
  parameter int unsigned Depth = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_i,
  input  job_t wr_data_i,
  input  logic rd_i,
  output job_t rd_data_o,
  output logic full_o,
  output logic empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);
  localparam logic [PtrW-1:0] PtrOne = PtrW'(1);
  localparam logic [CntW-1:0] CntOne = CntW'(1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_wr, do_rd;

  assign full_o    = (cnt_q == FullCnt);
  assign empty_o   = (cnt_q == '0);
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrOne;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrOne;
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + CntOne;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - CntOne;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

>>> design/u8d_back.sv
// back end: expands each job into results and holds the output register
module u8d_back
  import u8d_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               job_valid_i,
  input  job_t               job_i,
  output logic               job_pop_o,
  input  logic               pop_i,
  output logic               empty_o,
  output logic [CpWidth-1:0] code_point_o,
  output logic               replaced_o,
  output logic               run_last_o,
  output logic               text_end_o
);

  logic [1:0]         step_q, step_d;
  logic               valid_q, valid_d;
  logic [CpWidth-1:0] cp_q;
  logic               repl_q, last_q, end_q;
  logic [2:0]         total;
  logic [2:0]         idx;
  logic               load;
  logic               is_data;
  logic               is_last;

  assign total   = job_i.pre_reps + {2'b00, job_i.has_data} + {1'b0, job_i.post_reps};
  assign idx     = {1'b0, step_q};
  assign is_data = job_i.has_data && (idx == job_i.pre_reps);
  assign is_last = ((idx + 3'd1) == total);
  assign load    = job_valid_i && (!valid_q || pop_i);

  assign job_pop_o = load && is_last;

  always_comb begin
    step_d  = step_q;
    valid_d = valid_q;
    if (load) begin
      step_d  = is_last ? 2'd0 : step_q + 2'd1;
      valid_d = 1'b1;
    end else if (pop_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= 2'd0;
      valid_q <= 1'b0;
    end else begin
      step_q  <= step_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cp_q   <= is_data ? job_i.data_cp : ReplCp;
      repl_q <= !is_data;
      last_q <= is_last;
      end_q  <= is_last && job_i.fin;
    end
  end

  assign empty_o      = !valid_q;
  assign code_point_o = cp_q;
  assign replaced_o   = repl_q;
  assign run_last_o   = last_q;
  assign text_end_o   = end_q;

endmodule

>>> tb/utf8_stream_decoder_tb.sv
// self-checking testbench for the utf-8 stream decoder with random stalls on both sides
module utf8_stream_decoder_tb;
  import u8d_pkg::*;

  localparam int CycleLimit = 400000;

  typedef struct packed {
    logic [CpWidth-1:0] code_point;
    logic               replaced;
    logic               run_last;
    logic               text_end;
  } cp_result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               push_i = 1'b0;
  logic [7:0]         text_byte_i = 8'h00;
  logic               final_byte_i = 1'b0;
  logic               pop_i = 1'b0;
  logic               full_o;
  logic               empty_o;
  logic [CpWidth-1:0] code_point_o;
  logic               replaced_o;
  logic               run_last_o;
  logic               text_end_o;

  // decoder state mirrored by the predictor
  logic [CpWidth-1:0] seq_value = '0;
  logic [1:0]         seq_need = '0;
  logic [1:0]         seq_held = '0;

  cp_result_t step_results[$];
  cp_result_t expected_cps[$];
  int         fail_count = 0;
  int         items_sent = 0;
  int         cycle_count = 0;
  int         rx_hold = 0;
  logic       tx_idle_on = 1'b1;
  logic       rx_idle_on = 1'b1;

  utf8_stream_decoder u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_i),
    .full_o      (full_o),
    .text_byte_i (text_byte_i),
    .final_byte_i(final_byte_i),
    .pop_i       (pop_i),
    .empty_o     (empty_o),
    .code_point_o(code_point_o),
    .replaced_o  (replaced_o),
    .run_last_o  (run_last_o),
    .text_end_o  (text_end_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic int pick_gap(input logic idle_on);
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic pick_fin();
    return ($urandom_range(0, 24) == 0);
  endfunction

  function automatic logic [7:0] lead_for(input int len);
    logic [7:0] r;
    r = 8'($urandom_range(0, 255));
    case (len)
      1: return {1'b0, r[6:0]};
      2: return {3'b110, r[4:0]};
      3: return {4'b1110, r[3:0]};
      default: return {5'b11110, r[2:0]};
    endcase
  endfunction

  function automatic logic [7:0] cont_byte();
    logic [7:0] r;
    r = 8'($urandom_range(0, 255));
    return {ContTag, r[5:0]};
  endfunction

  function automatic void add_result(input logic [CpWidth-1:0] cp, input logic repl);
    cp_result_t res;
    res.code_point = cp;
    res.replaced   = repl;
    res.run_last   = 1'b0;
    res.text_end   = 1'b0;
    step_results = {step_results, res};
  endfunction

  // one replacement for the lead and one per held continuation
  function automatic void flush_sequence();
    if (seq_need != 0) begin
      for (int k = 0; k <= seq_held; k++) add_result(ReplCp, 1'b1);
    end
    seq_value = '0;
    seq_need  = '0;
    seq_held  = '0;
  endfunction

  function automatic void predict_decode(input logic [7:0] b, input logic fin);
    logic taken;
    cp_result_t last;
    taken = 1'b0;
    step_results.delete();
    if (seq_need != 0) begin
      if (b[7:6] == ContTag) begin
        seq_value = {seq_value[CpWidth-7:0], b[5:0]};
        seq_held  = seq_held + 2'd1;
        if (seq_held == seq_need) begin
          add_result(seq_value, 1'b0);
          seq_value = '0;
          seq_need  = '0;
          seq_held  = '0;
        end
        taken = 1'b1;
      end else begin
        flush_sequence();
      end
    end
    if (!taken) begin
      if (b < AsciiTop) begin
        add_result({13'b0, b}, 1'b0);
      end else if (b < LeadTwo) begin
        add_result(ReplCp, 1'b1);
      end else if (b < LeadThree) begin
        seq_value = {16'b0, b[4:0]};
        seq_need  = 2'd1;
        seq_held  = '0;
      end else if (b < LeadFour) begin
        seq_value = {17'b0, b[3:0]};
        seq_need  = 2'd2;
        seq_held  = '0;
      end else if (b < LeadBad) begin
        seq_value = {18'b0, b[2:0]};
        seq_need  = 2'd3;
        seq_held  = '0;
      end else begin
        add_result(ReplCp, 1'b1);
      end
    end
    if (fin) flush_sequence();
    if (step_results.size() > 0) begin
      last = step_results.pop_back();
      last.run_last = 1'b1;
      last.text_end = fin;
      step_results = {step_results, last};
    end
    foreach (step_results[i]) expected_cps = {expected_cps, step_results[i]};
  endfunction

  task automatic send_text_byte(input logic [7:0] b, input logic fin);
    int gap;
    gap = pick_gap(tx_idle_on);
    if (gap > 0) begin
      push_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push_i       <= 1'b1;
    text_byte_i  <= b;
    final_byte_i <= fin;
    do @(posedge clk_i); while (full_o);
    predict_decode(b, fin);
    items_sent++;
  endtask

  task automatic send_random_char();
    int len;
    len = $urandom_range(1, 4);
    send_text_byte(lead_for(len), pick_fin());
    for (int k = 1; k < len; k++) send_text_byte(cont_byte(), pick_fin());
  endtask

  task automatic wait_drained();
    push_i <= 1'b0;
    while (expected_cps.size() != 0) @(posedge clk_i);
  endtask

  task automatic check_result();
    cp_result_t exp_res;
    if (expected_cps.size() == 0) begin
      $error("result with nothing expected: code_point %0h", code_point_o);
      fail_count++;
      return;
    end
    exp_res = expected_cps.pop_front();
    if (code_point_o !== exp_res.code_point) begin
      $error("code_point expected %0h got %0h", exp_res.code_point, code_point_o);
      fail_count++;
    end
    if (replaced_o !== exp_res.replaced) begin
      $error("replaced expected %0b got %0b", exp_res.replaced, replaced_o);
      fail_count++;
    end
    if (run_last_o !== exp_res.run_last) begin
      $error("run_last expected %0b got %0b", exp_res.run_last, run_last_o);
      fail_count++;
    end
    if (text_end_o !== exp_res.text_end) begin
      $error("text_end expected %0b got %0b", exp_res.text_end, text_end_o);
      fail_count++;
    end
  endtask

  // result side: checks each transfer and stalls at random
  initial begin
    int   rx_stall;
    logic xfer;
    rx_stall = 0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      xfer = pop_i && !empty_o;
      if (xfer) begin
        check_result();
        rx_stall = pick_gap(rx_idle_on);
      end
      if (rx_hold > 0) begin
        rx_hold--;
        pop_i <= 1'b0;
      end else if (rx_stall > 0) begin
        rx_stall--;
        pop_i <= 1'b0;
      end else begin
        pop_i <= 1'b1;
      end
    end
  end

  task automatic test_single_bytes();
    send_text_byte(8'h00, 1'b0);
    send_text_byte(8'h7F, 1'b0);
    send_text_byte(8'h80, 1'b0);
    send_text_byte(8'hBF, 1'b0);
    send_text_byte(8'hF8, 1'b0);
    send_text_byte(8'hFF, 1'b1);
  endtask

  task automatic test_full_sequences();
    send_text_byte(8'hC0, 1'b0);
    send_text_byte(8'h80, 1'b0);
    send_text_byte(8'hEF, 1'b0);
    send_text_byte(8'hBF, 1'b0);
    send_text_byte(8'hBF, 1'b0);
    send_text_byte(8'hF7, 1'b0);
    send_text_byte(8'hBF, 1'b0);
    send_text_byte(8'hBF, 1'b0);
    send_text_byte(8'hBF, 1'b0);
  endtask

  task automatic test_breaks_and_early_end();
    // broken by ascii
    send_text_byte(8'hE1, 1'b0);
    send_text_byte(8'h80, 1'b0);
    send_text_byte(8'h41, 1'b0);
    // broken by a lead on the last byte: four replacements
    send_text_byte(8'hF0, 1'b0);
    send_text_byte(8'h80, 1'b0);
    send_text_byte(8'h80, 1'b0);
    send_text_byte(8'hF5, 1'b1);
    // text ends on a bare lead
    send_text_byte(8'hC2, 1'b1);
    send_text_byte(8'h41, 1'b1);
  endtask

  task automatic test_back_pressure();
    tx_idle_on = 1'b0;
    rx_hold = 200;
    repeat (8) send_random_char();
    wait_drained();
    tx_idle_on = 1'b1;
  endtask

  task automatic test_random_text(input int count);
    int         first;
    int         kind;
    int         len;
    int         phase;
    logic [7:0] b;
    first = items_sent;
    while (items_sent - first < count) begin
      phase = (items_sent - first) * 3 / count;
      tx_idle_on = (phase != 1);
      rx_idle_on = (phase != 2);
      kind = $urandom_range(0, 99);
      if (kind < 72) begin
        send_random_char();
      end else if (kind < 84) begin
        send_text_byte(8'($urandom_range(0, 255)), pick_fin());
      end else begin
        len = $urandom_range(2, 4);
        send_text_byte(lead_for(len), 1'b0);
        repeat ($urandom_range(0, len - 2)) send_text_byte(cont_byte(), 1'b0);
        do b = 8'($urandom_range(0, 255)); while (b[7:6] == ContTag);
        send_text_byte(b, pick_fin());
      end
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_single_bytes();
    test_full_sequences();
    test_breaks_and_early_end();
    test_back_pressure();
    test_random_text(270);
    wait_drained();
    rx_idle_on = 1'b0;
    repeat (10) @(posedge clk_i);
    if (fail_count == 0 && expected_cps.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> utf8_stream_decoder.f
design/u8d_pkg.sv
design/u8d_front.sv
design/u8d_fifo.sv
design/u8d_back.sv
design/utf8_stream_decoder.sv
tb/utf8_stream_decoder_tb.sv
